// ===== hw/rtl/srctok_pkg.sv =====
// srctok_pkg: shared types, constants and character-class functions of the
// source tokenizer. No dependencies; used by every module of the block.
`default_nettype none

package srctok_pkg;

  localparam int POS_BITS = 32;   // width of the offset, line and column counters
  localparam int OUT_BITS = 32;   // width of the position fields on the result port
  localparam int TAB_BITS = 5;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_BITS  = $clog2(QUEUE_DEPTH + 1);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [OUT_BITS-1:0] out_pos_t;

  localparam pos_t POS_ONE = pos_t'(1);
  localparam logic [TAB_BITS-1:0] TAB_RESET = TAB_BITS'(4);

  // character codes
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_BAR     = 8'h7C;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;

  typedef enum logic [4:0] {
    KIND_NAME    = 5'd0,
    KIND_NUMBER  = 5'd1,
    KIND_STRING  = 5'd2,
    KIND_ARROW   = 5'd3,
    KIND_NE      = 5'd4,
    KIND_LE      = 5'd5,
    KIND_GE      = 5'd6,
    KIND_AND     = 5'd7,
    KIND_OR      = 5'd8,
    KIND_LPAREN  = 5'd9,
    KIND_RPAREN  = 5'd10,
    KIND_LBRACE  = 5'd11,
    KIND_RBRACE  = 5'd12,
    KIND_SEMI    = 5'd13,
    KIND_COLON   = 5'd14,
    KIND_COMMA   = 5'd15,
    KIND_DOT     = 5'd16,
    KIND_PLUS    = 5'd17,
    KIND_MINUS   = 5'd18,
    KIND_STAR    = 5'd19,
    KIND_SLASH   = 5'd20,
    KIND_PERCENT = 5'd21,
    KIND_ASSIGN  = 5'd22,
    KIND_LT      = 5'd23,
    KIND_GT      = 5'd24,
    KIND_BANG    = 5'd25,
    KIND_CARET   = 5'd26,
    KIND_UNKNOWN = 5'd27
  } kind_t;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_NAME   = 6'b000010,
    MODE_NUMBER = 6'b000100,
    MODE_STRING = 6'b001000,
    MODE_ESCAPE = 6'b010000,
    MODE_HELD   = 6'b100000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       quote_single;
    logic [7:0] held;
    pos_t       tok_start;
    pos_t       tok_col;
    pos_t       offset;
    pos_t       line;
    pos_t       col;
  } scan_state_t;

  typedef struct packed {
    kind_t    kind;
    out_pos_t start_off;
    out_pos_t end_off;
    out_pos_t line;
    out_pos_t column;
    logic     last;
  } token_t;

  // tokens produced by one input byte, in order
  typedef struct packed {
    logic [1:0] n_tokens;
    token_t     first;
    token_t     second;
  } step_out_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_pair_starter(logic [7:0] c);
    return c == CH_MINUS || c == CH_BANG || c == CH_LT || c == CH_GT ||
           c == CH_AMP || c == CH_BAR;
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    kind_t k;
    case (c)
      CH_LPAREN:  k = KIND_LPAREN;
      CH_RPAREN:  k = KIND_RPAREN;
      CH_LBRACE:  k = KIND_LBRACE;
      CH_RBRACE:  k = KIND_RBRACE;
      CH_SEMI:    k = KIND_SEMI;
      CH_COLON:   k = KIND_COLON;
      CH_COMMA:   k = KIND_COMMA;
      CH_DOT:     k = KIND_DOT;
      CH_PLUS:    k = KIND_PLUS;
      CH_MINUS:   k = KIND_MINUS;
      CH_STAR:    k = KIND_STAR;
      CH_SLASH:   k = KIND_SLASH;
      CH_PERCENT: k = KIND_PERCENT;
      CH_EQ:      k = KIND_ASSIGN;
      CH_LT:      k = KIND_LT;
      CH_GT:      k = KIND_GT;
      CH_BANG:    k = KIND_BANG;
      CH_CARET:   k = KIND_CARET;
      default:    k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic pair_hit(logic [7:0] first, logic [7:0] c);
    return (first == CH_MINUS && c == CH_GT) || (first == CH_BANG && c == CH_EQ) ||
           (first == CH_LT && c == CH_EQ) || (first == CH_GT && c == CH_EQ) ||
           (first == CH_AMP && c == CH_AMP) || (first == CH_BAR && c == CH_BAR);
  endfunction

  // only meaningful where pair_hit is true
  function automatic kind_t pair_kind(logic [7:0] first);
    kind_t k;
    case (first)
      CH_MINUS: k = KIND_ARROW;
      CH_BANG:  k = KIND_NE;
      CH_LT:    k = KIND_LE;
      CH_GT:    k = KIND_GE;
      CH_AMP:   k = KIND_AND;
      CH_BAR:   k = KIND_OR;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/srctok_step.sv =====
// srctok_step: next-state and token logic for one source byte.
// Depends on srctok_pkg.
`default_nettype none

module srctok_step (
  input  wire srctok_pkg::scan_state_t cur,
  input  wire logic [7:0]              char_byte,
  input  wire logic                    end_of_input,
  input  wire logic [srctok_pkg::TAB_BITS-1:0] tab_width,
  output srctok_pkg::scan_state_t      nxt,
  output srctok_pkg::step_out_t        result
);

  function automatic srctok_pkg::token_t make_tok(srctok_pkg::kind_t k, srctok_pkg::pos_t s,
                                                  srctok_pkg::pos_t e, srctok_pkg::pos_t ln,
                                                  srctok_pkg::pos_t cl);
    srctok_pkg::token_t t;
    t.kind      = k;
    t.start_off = srctok_pkg::OUT_BITS'(s);
    t.end_off   = srctok_pkg::OUT_BITS'(e);
    t.line      = srctok_pkg::OUT_BITS'(ln);
    t.column    = srctok_pkg::OUT_BITS'(cl);
    t.last      = 1'b0;
    return t;
  endfunction

  srctok_pkg::scan_state_t st;
  srctok_pkg::token_t      a_tok, b_tok, c_tok;
  logic                    a_v, b_v, c_v;
  logic                    consumed;
  logic [1:0]              n_tok;

  always_comb begin
    st       = cur;
    consumed = 1'b0;
    a_v      = 1'b0;
    b_v      = 1'b0;
    c_v      = 1'b0;
    a_tok    = '0;
    b_tok    = '0;
    c_tok    = '0;

    // continue the token in progress
    case (cur.mode)
      srctok_pkg::MODE_STRING: begin
        consumed = 1'b1;
        if (char_byte == srctok_pkg::CH_BSLASH) begin
          st.mode   = srctok_pkg::MODE_ESCAPE;
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
        end else if (char_byte == (st.quote_single ? srctok_pkg::CH_SQUOTE
                                                    : srctok_pkg::CH_DQUOTE)) begin
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
          a_v       = 1'b1;
          a_tok     = make_tok(srctok_pkg::KIND_STRING, st.tok_start, st.offset, st.line,
                               st.tok_col);
          st.mode   = srctok_pkg::MODE_IDLE;
        end else if (char_byte == srctok_pkg::CH_LF) begin
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.line   = st.line + srctok_pkg::POS_ONE;
          st.col    = srctok_pkg::POS_ONE;
        end else begin
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
        end
      end
      srctok_pkg::MODE_ESCAPE: begin
        // escaped byte only moves the offset and the column, even a newline
        consumed  = 1'b1;
        st.mode   = srctok_pkg::MODE_STRING;
        st.offset = st.offset + srctok_pkg::POS_ONE;
        st.col    = st.col + srctok_pkg::POS_ONE;
      end
      srctok_pkg::MODE_NAME: begin
        if (srctok_pkg::is_alpha(char_byte) || srctok_pkg::is_digit(char_byte) ||
            char_byte == srctok_pkg::CH_UNDER) begin
          consumed  = 1'b1;
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
        end else begin
          a_v     = 1'b1;
          a_tok   = make_tok(srctok_pkg::KIND_NAME, st.tok_start, st.offset, st.line,
                             st.tok_col);
          st.mode = srctok_pkg::MODE_IDLE;
        end
      end
      srctok_pkg::MODE_NUMBER: begin
        if (srctok_pkg::is_digit(char_byte) || char_byte == srctok_pkg::CH_DOT) begin
          consumed  = 1'b1;
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
        end else begin
          a_v     = 1'b1;
          a_tok   = make_tok(srctok_pkg::KIND_NUMBER, st.tok_start, st.offset, st.line,
                             st.tok_col);
          st.mode = srctok_pkg::MODE_IDLE;
        end
      end
      srctok_pkg::MODE_HELD: begin
        a_v = 1'b1;
        if (srctok_pkg::pair_hit(st.held, char_byte)) begin
          consumed  = 1'b1;
          a_tok     = make_tok(srctok_pkg::pair_kind(st.held), st.tok_start,
                               st.offset + srctok_pkg::POS_ONE, st.line, st.tok_col);
          st.offset = st.offset + srctok_pkg::POS_ONE;
          st.col    = st.col + srctok_pkg::POS_ONE;
        end else begin
          a_tok = make_tok(srctok_pkg::single_kind(st.held), st.tok_start, st.offset,
                           st.line, st.tok_col);
        end
        st.mode = srctok_pkg::MODE_IDLE;
      end
      default: begin
        st.mode = srctok_pkg::MODE_IDLE;
      end
    endcase

    // byte not taken by a token in progress starts fresh
    if (!consumed) begin
      if (char_byte == srctok_pkg::CH_LF) begin
        st.offset = st.offset + srctok_pkg::POS_ONE;
        st.line   = st.line + srctok_pkg::POS_ONE;
        st.col    = srctok_pkg::POS_ONE;
      end else if (char_byte == srctok_pkg::CH_TAB) begin
        st.offset = st.offset + srctok_pkg::POS_ONE;
        st.col    = st.col + srctok_pkg::POS_BITS'(tab_width);
      end else if (srctok_pkg::is_space(char_byte)) begin
        st.offset = st.offset + srctok_pkg::POS_ONE;
        st.col    = st.col + srctok_pkg::POS_ONE;
      end else begin
        if (char_byte == srctok_pkg::CH_DQUOTE || char_byte == srctok_pkg::CH_SQUOTE) begin
          st.mode         = srctok_pkg::MODE_STRING;
          st.quote_single = (char_byte == srctok_pkg::CH_SQUOTE);
          st.tok_start    = st.offset;
          st.tok_col      = st.col;
        end else if (srctok_pkg::is_alpha(char_byte) ||
                     char_byte == srctok_pkg::CH_UNDER) begin
          st.mode      = srctok_pkg::MODE_NAME;
          st.tok_start = st.offset;
          st.tok_col   = st.col;
        end else if (srctok_pkg::is_digit(char_byte)) begin
          st.mode      = srctok_pkg::MODE_NUMBER;
          st.tok_start = st.offset;
          st.tok_col   = st.col;
        end else if (srctok_pkg::is_pair_starter(char_byte)) begin
          st.mode      = srctok_pkg::MODE_HELD;
          st.held      = char_byte;
          st.tok_start = st.offset;
          st.tok_col   = st.col;
        end else begin
          b_v   = 1'b1;
          b_tok = make_tok(srctok_pkg::single_kind(char_byte), st.offset,
                           st.offset + srctok_pkg::POS_ONE, st.line, st.col);
        end
        st.offset = st.offset + srctok_pkg::POS_ONE;
        st.col    = st.col + srctok_pkg::POS_ONE;
      end
    end

    // end of input flushes whatever is pending
    if (end_of_input) begin
      case (st.mode)
        srctok_pkg::MODE_NAME: begin
          c_v   = 1'b1;
          c_tok = make_tok(srctok_pkg::KIND_NAME, st.tok_start, st.offset, st.line,
                           st.tok_col);
        end
        srctok_pkg::MODE_NUMBER: begin
          c_v   = 1'b1;
          c_tok = make_tok(srctok_pkg::KIND_NUMBER, st.tok_start, st.offset, st.line,
                           st.tok_col);
        end
        srctok_pkg::MODE_STRING, srctok_pkg::MODE_ESCAPE: begin
          c_v   = 1'b1;
          c_tok = make_tok(srctok_pkg::KIND_STRING, st.tok_start, st.offset, st.line,
                           st.tok_col);
        end
        srctok_pkg::MODE_HELD: begin
          c_v   = 1'b1;
          c_tok = make_tok(srctok_pkg::single_kind(st.held), st.tok_start, st.offset,
                           st.line, st.tok_col);
        end
        default: begin
          c_v = 1'b0;
        end
      endcase
      st.mode = srctok_pkg::MODE_IDLE;
    end
  end

  // at most two of the three sources fire for one byte
  always_comb begin
    n_tok = 2'(a_v) + 2'(b_v) + 2'(c_v);
    if (n_tok > 2'd2) begin
      n_tok = 2'd2;
    end
    result.n_tokens = n_tok;
    result.first    = a_v ? a_tok : (b_v ? b_tok : c_tok);
    result.second   = (a_v && b_v) ? b_tok : c_tok;
    if (n_tok == 2'd1) begin
      result.first.last = 1'b1;
    end
    if (n_tok == 2'd2) begin
      result.second.last = 1'b1;
    end
  end

  assign nxt = st;

endmodule

`default_nettype wire

// ===== hw/rtl/srctok_queue.sv =====
// srctok_queue: token result queue, takes up to two tokens per cycle while it has room and
// hands out one per cycle while popped. Depends on srctok_pkg.
`default_nettype none

module srctok_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire srctok_pkg::step_out_t push_data,
  input  wire logic                  pop,
  output srctok_pkg::token_t         head,
  output logic                       nonempty,
  output logic                       room,
  output logic [srctok_pkg::LEVEL_BITS-1:0] level
);

  srctok_pkg::token_t entries [srctok_pkg::QUEUE_DEPTH];

  logic [srctok_pkg::PTR_BITS-1:0]   rd_ptr;
  logic [srctok_pkg::PTR_BITS-1:0]   wr_ptr;
  logic [srctok_pkg::LEVEL_BITS-1:0] count;
  logic [1:0]                        n_push;
  logic                              do_pop;

  assign n_push   = push ? push_data.n_tokens : 2'd0;
  assign do_pop   = pop && (count != '0);
  assign nonempty = (count != '0);
  // a byte may produce two tokens, so keep two slots free before accepting
  assign room     = (count <= srctok_pkg::LEVEL_BITS'(srctok_pkg::QUEUE_DEPTH - 2));
  assign head     = entries[rd_ptr];
  assign level    = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + srctok_pkg::PTR_BITS'(do_pop);
      wr_ptr <= wr_ptr + srctok_pkg::PTR_BITS'(n_push);
      count  <= count + srctok_pkg::LEVEL_BITS'(n_push) - srctok_pkg::LEVEL_BITS'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= push_data.first;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + srctok_pkg::PTR_BITS'(1)] <= push_data.second;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/source_tokenizer.sv =====
// source_tokenizer: byte-serial lexical analyzer, top level.
// Depends on srctok_pkg, srctok_step and srctok_queue.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   char     | char_valid / char_ready     | char_byte, end_of_input
//   token    | token_valid / token_ready   | token_kind, start_offset, end_offset,
//            |                             | line_number, start_column, last_of_run
//   config   | cfg_write_en (no wait)      | cfg_write_data = tab_width
//
// One byte is accepted per cycle while char_ready is high; its tokens are in the
// result queue the next cycle. The queue (four entries) drains one token per
// cycle while token_ready is high, so the tokens of a byte leave one at a time;
// char_ready drops while fewer than two entries are free. Synchronous reset clears
// scanner state, counters (line and column to 1), the queue and sets tab_width to 4.
`default_nettype none

module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        char_valid,
  output logic             char_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        end_of_input,
  output logic             token_valid,
  input  wire logic        token_ready,
  output logic [4:0]       token_kind,
  output logic [31:0]      start_offset,
  output logic [31:0]      end_offset,
  output logic [31:0]      line_number,
  output logic [31:0]      start_column,
  output logic             last_of_run,
  input  wire logic        cfg_write_en,
  input  wire logic [4:0]  cfg_write_data
);

  srctok_pkg::scan_state_t state;
  srctok_pkg::scan_state_t state_next;
  srctok_pkg::step_out_t   step_res;
  srctok_pkg::token_t      head;
  logic [srctok_pkg::TAB_BITS-1:0]   tab_width;
  logic [srctok_pkg::LEVEL_BITS-1:0] level;
  logic                    room;
  logic                    accept;

  assign accept     = char_valid && char_ready;
  assign char_ready = room;

  srctok_step u_step (
    .cur          (state),
    .char_byte    (char_byte),
    .end_of_input (end_of_input),
    .tab_width    (tab_width),
    .nxt          (state_next),
    .result       (step_res)
  );

  srctok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .pop       (token_ready),
    .head      (head),
    .nonempty  (token_valid),
    .room      (room),
    .level     (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= srctok_pkg::MODE_IDLE;
      state.quote_single <= 1'b0;
      state.held         <= '0;
      state.tok_start    <= '0;
      state.tok_col      <= '0;
      state.offset       <= '0;
      state.line         <= srctok_pkg::POS_ONE;
      state.col          <= srctok_pkg::POS_ONE;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width <= srctok_pkg::TAB_RESET;
    end else if (cfg_write_en) begin
      tab_width <= cfg_write_data;
    end
  end

  assign token_kind   = head.kind;
  assign start_offset = head.start_off;
  assign end_offset   = head.end_off;
  assign line_number  = head.line;
  assign start_column = head.column;
  assign last_of_run  = head.last;

  // every accepted byte moves the offset by exactly one
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state.offset == $past(state.offset) + srctok_pkg::POS_ONE)
    else $error("byte offset did not advance by one");

  // end of input always leaves the scanner idle
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_input |=> state.mode == srctok_pkg::MODE_IDLE)
    else $error("scanner not idle after end of input");

  // an unescaped newline restarts the column
  assert property (@(posedge clk) disable iff (rst)
    accept && char_byte == srctok_pkg::CH_LF && state.mode != srctok_pkg::MODE_ESCAPE
    |=> state.col == srctok_pkg::POS_ONE)
    else $error("column not reset by newline");

  // the queue never overflows
  assert property (@(posedge clk) disable iff (rst)
    level <= srctok_pkg::LEVEL_BITS'(srctok_pkg::QUEUE_DEPTH))
    else $error("token queue overflow");

endmodule

`default_nettype wire
